[rtl/nbd_pkg.sv]
`timescale 1ns / 1ps
package nbd_pkg;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } nbd_req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] option_code;
      logic [2:0]  option_outcome;
      logic        skip_zero_padding;
      logic [15:0] request_flags;
      logic [15:0] request_kind;
      logic [63:0] request_handle;
      logic [63:0] request_offset;
      logic [31:0] request_length;
      logic [7:0]  payload_byte;
      logic        last;
   } nbd_rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_FLAGS = 3'd1,
      PH_OHDR  = 3'd2,
      PH_OPAY  = 3'd3,
      PH_RHDR  = 3'd4,
      PH_WPAY  = 3'd5
   } nbd_phase_type;

   localparam logic [1:0]  REQ_CONNECT = 2'd0;
   localparam logic [1:0]  REQ_BYTE    = 2'd1;
   localparam logic [1:0]  REQ_CLOSE   = 2'd2;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;

   localparam logic [1:0]  REG_MAX_WRITE = 2'd0;

   localparam logic [2:0]  EV_OPTION   = 3'd1;
   localparam logic [2:0]  EV_REQUEST  = 3'd2;
   localparam logic [2:0]  EV_WBYTE    = 3'd3;
   localparam logic [2:0]  EV_DROP     = 3'd4;
   localparam logic [2:0]  EV_DISC     = 3'd5;
   localparam logic [2:0]  EV_CLOSED   = 3'd6;
   localparam logic [2:0]  EV_LEFT     = 3'd7;

   localparam logic [2:0]  OC_EXPORT   = 3'd0;
   localparam logic [2:0]  OC_ABORT    = 3'd1;
   localparam logic [2:0]  OC_LIST_OK  = 3'd2;
   localparam logic [2:0]  OC_LIST_BAD = 3'd3;
   localparam logic [2:0]  OC_INFO_OK  = 3'd4;
   localparam logic [2:0]  OC_GO_OK    = 3'd5;
   localparam logic [2:0]  OC_IG_BAD   = 3'd6;
   localparam logic [2:0]  OC_UNSUPP   = 3'd7;

   localparam logic [63:0] OPT_MAGIC   = 64'h4948_4156_454F_5054;
   localparam logic [31:0] REQ_MAGIC   = 32'h2560_9513;
   localparam logic [31:0] OPTC_EXPORT = 32'd1;
   localparam logic [31:0] OPTC_ABORT  = 32'd2;
   localparam logic [31:0] OPTC_LIST   = 32'd3;
   localparam logic [31:0] OPTC_INFO   = 32'd6;
   localparam logic [31:0] OPTC_GO     = 32'd7;
   localparam logic [15:0] CMD_WRITE   = 16'd1;
   localparam logic [15:0] CMD_DISC    = 16'd2;
   localparam logic [7:0]  FLAG_FIXED  = 8'h01;
   localparam logic [7:0]  FLAG_NOPAD  = 8'h02;
   localparam logic [25:0] MAX_WRITE_RESET = 26'd1048576;

endpackage

[rtl/nbd_server_stream_parser.sv]
`timescale 1ns / 1ps
// pipeline: two register stages (queue then output register); a beat passes through the
//   queue, then its result is held in the output register until it is taken
// throughput: one beat per cycle unless rsp_ready stalls; the output register and two-entry queue absorb stalls
// reset: synchronous active high; parser idle with no client, max_write_length = 1048576
module nbd_server_stream_parser #(
   parameter int MAX_OPTION_LENGTH = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nbd_pkg::nbd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nbd_pkg::nbd_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [1:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import nbd_pkg::*;

   logic [25:0] mwl_ff, mwl_in;
   logic        q_valid, q_ready;
   nbd_req_type q_data;

   // configuration register
   assign pready = 1'b1;
   assign prdata = (paddr == REG_MAX_WRITE) ? {6'd0, mwl_ff} : 32'd0;
   always_comb begin
      mwl_in = mwl_ff;
      if (psel && penable && pwrite && paddr == REG_MAX_WRITE) mwl_in = pwdata[25:0];
   end
   always_ff @(posedge clock) begin
      if (reset) mwl_ff <= MAX_WRITE_RESET;
      else mwl_ff <= mwl_in;
   end

   nbd_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   nbd_back #(
      .MAX_OPTION_LENGTH(MAX_OPTION_LENGTH)
   ) u_back (
      .clock, .reset, .max_write(mwl_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );
endmodule

[rtl/nbd_queue.sv]
`timescale 1ns / 1ps
module nbd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  nbd_pkg::nbd_req_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output nbd_pkg::nbd_req_type out_data
);
   import nbd_pkg::*;

   // two-entry queue between front and back
   nbd_req_type mem_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule

[rtl/nbd_back.sv]
`timescale 1ns / 1ps
module nbd_back #(
   parameter int MAX_OPTION_LENGTH = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [25:0]          max_write,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  nbd_pkg::nbd_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output nbd_pkg::nbd_rsp_type out_data
);
   import nbd_pkg::*;

   localparam logic [32:0] MAX_OPT = 33'(MAX_OPTION_LENGTH);

   nbd_phase_type phase_ff, phase_in;
   logic [25:0] idx_ff, idx_in;
   logic [63:0] wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in;
   logic [31:0] wd_ff, wd_in, nl_ff, nl_in;
   logic [15:0] irc_ff, irc_in;
   logic        npad_ff, npad_in;
   logic        ov_ff, ov_in;
   nbd_rsp_type od_ff, od_in;
   logic        emit;
   nbd_rsp_type ev;
   logic [7:0]  b;
   logic [31:0] size, i32;
   logic [32:0] at;
   logic [33:0] need;
   logic        irc_hit;
   logic [15:0] irc_nx;
   logic        ig_ok;

   // output register frees when taken
   assign in_ready  = !ov_ff || out_ready;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign b = in_data.rx_byte;

   // option size and info/go payload check, including the count byte of this beat
   always_comb begin
      size    = wb_ff[31:0];
      i32     = {6'd0, idx_ff};
      at      = 33'd4 + {1'b0, nl_ff};
      irc_hit = (idx_ff >= 26'd4) && ({1'b0, i32} == at || {1'b0, i32} == at + 33'd1);
      irc_nx  = irc_hit ? {irc_ff[7:0], b} : irc_ff;
      need    = 34'd6 + {2'd0, nl_ff} + {17'd0, irc_nx, 1'b0};
      ig_ok   = (size >= 32'd6) && (nl_ff <= size - 32'd6) && (need == {2'd0, size});
   end

   // byte parser
   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      wa_in = wa_ff; wb_in = wb_ff; wc_in = wc_ff; wd_in = wd_ff;
      nl_in = nl_ff; irc_in = irc_ff; npad_in = npad_ff;
      emit = 1'b0;
      ev = '0;
      case (in_data.req_type)
         REQ_CONNECT: begin
            phase_in = PH_FLAGS; idx_in = '0; wa_in = '0; npad_in = 1'b0;
         end
         REQ_CLOSE: begin
            if (phase_ff == PH_RHDR || phase_ff == PH_WPAY) begin
               emit = 1'b1; ev.event_kind = EV_CLOSED;
            end else if (phase_ff != PH_IDLE) begin
               emit = 1'b1; ev.event_kind = EV_LEFT;
            end
            phase_in = PH_IDLE; idx_in = '0;
         end
         REQ_BYTE: begin
            case (phase_ff)
               PH_FLAGS: begin
                  wa_in = {32'd0, wa_ff[23:0], b};
                  idx_in = idx_ff + 26'd1;
                  if (idx_ff >= 26'd3) begin
                     npad_in = (|(b & FLAG_FIXED)) && (|(b & FLAG_NOPAD));
                     phase_in = PH_OHDR; idx_in = '0;
                  end
               end
               PH_OHDR: begin
                  if (idx_ff < 26'd8) wa_in = {wa_ff[55:0], b};
                  else if (idx_ff < 26'd12) wd_in = {wd_ff[23:0], b};
                  else wb_in = {32'd0, wb_ff[23:0], b};
                  idx_in = idx_ff + 26'd1;
                  if (idx_ff >= 26'd15) begin
                     if (wa_ff != OPT_MAGIC || {1'b0, wb_in[31:0]} > MAX_OPT) begin
                        phase_in = PH_IDLE; idx_in = '0;
                        emit = 1'b1; ev.event_kind = EV_DROP;
                     end else begin
                        nl_in = '0; irc_in = '0; idx_in = '0;
                        if (wb_in[31:0] == 32'd0) begin
                           emit = 1'b1;
                           ev.event_kind = EV_OPTION;
                           ev.option_code = wd_ff;
                           ev.skip_zero_padding = npad_ff;
                           phase_in = PH_OHDR;
                           case (wd_ff)
                              OPTC_EXPORT: begin
                                 ev.option_outcome = OC_EXPORT; phase_in = PH_RHDR;
                              end
                              OPTC_ABORT: begin
                                 ev.option_outcome = OC_ABORT; phase_in = PH_IDLE;
                              end
                              OPTC_LIST: ev.option_outcome = OC_LIST_OK;
                              OPTC_INFO, OPTC_GO: ev.option_outcome = OC_IG_BAD;
                              default: ev.option_outcome = OC_UNSUPP;
                           endcase
                        end else begin
                           phase_in = PH_OPAY;
                        end
                     end
                  end
               end
               PH_OPAY: begin
                  if (idx_ff < 26'd4) nl_in = {nl_ff[23:0], b};
                  else irc_in = irc_nx;
                  idx_in = idx_ff + 26'd1;
                  if ({1'b0, i32} + 33'd1 >= {1'b0, size}) begin
                     emit = 1'b1;
                     ev.event_kind = EV_OPTION;
                     ev.option_code = wd_ff;
                     ev.skip_zero_padding = npad_ff;
                     phase_in = PH_OHDR; idx_in = '0;
                     case (wd_ff)
                        OPTC_EXPORT: begin
                           ev.option_outcome = OC_EXPORT; phase_in = PH_RHDR;
                        end
                        OPTC_ABORT: begin
                           ev.option_outcome = OC_ABORT; phase_in = PH_IDLE;
                        end
                        OPTC_LIST: ev.option_outcome = OC_LIST_BAD;
                        OPTC_INFO: ev.option_outcome = ig_ok ? OC_INFO_OK : OC_IG_BAD;
                        OPTC_GO: begin
                           if (ig_ok) begin
                              ev.option_outcome = OC_GO_OK; phase_in = PH_RHDR;
                           end else begin
                              ev.option_outcome = OC_IG_BAD;
                           end
                        end
                        default: ev.option_outcome = OC_UNSUPP;
                     endcase
                  end
               end
               PH_RHDR: begin
                  if (idx_ff < 26'd8) wa_in = {wa_ff[55:0], b};
                  else if (idx_ff < 26'd16) wb_in = {wb_ff[55:0], b};
                  else if (idx_ff < 26'd24) wc_in = {wc_ff[55:0], b};
                  else wd_in = {wd_ff[23:0], b};
                  idx_in = idx_ff + 26'd1;
                  if (idx_ff >= 26'd27) begin
                     idx_in = '0;
                     emit = 1'b1;
                     if (wa_ff[63:32] != REQ_MAGIC ||
                         (wa_ff[15:0] == CMD_WRITE && wd_in > {6'd0, max_write})) begin
                        phase_in = PH_IDLE;
                        ev.event_kind = EV_DROP;
                     end else begin
                        ev.event_kind = (wa_ff[15:0] == CMD_DISC) ? EV_DISC : EV_REQUEST;
                        ev.request_flags  = wa_ff[31:16];
                        ev.request_kind   = wa_ff[15:0];
                        ev.request_handle = wb_ff;
                        ev.request_offset = wc_ff;
                        ev.request_length = wd_in;
                        if (wa_ff[15:0] == CMD_DISC) phase_in = PH_IDLE;
                        else if (wa_ff[15:0] == CMD_WRITE && wd_in != 32'd0)
                           phase_in = PH_WPAY;
                     end
                  end
               end
               PH_WPAY: begin
                  emit = 1'b1;
                  ev.event_kind = EV_WBYTE;
                  ev.payload_byte = b;
                  ev.last = ({1'b0, i32} + 33'd1 >= {1'b0, wd_ff});
                  idx_in = idx_ff + 26'd1;
                  if (ev.last) begin
                     phase_in = PH_RHDR; idx_in = '0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // output register update
   always_comb begin
      ov_in = ov_ff && !out_ready;
      od_in = od_ff;
      if (in_valid && in_ready) begin
         ov_in = emit;
         od_in = ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff <= '0;
         wa_ff <= '0; wb_ff <= '0; wc_ff <= '0; wd_ff <= '0;
         nl_ff <= '0; irc_ff <= '0; npad_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (in_valid && in_ready) begin
            phase_ff <= phase_in;
            idx_ff <= idx_in;
            wa_ff <= wa_in; wb_ff <= wb_in; wc_ff <= wc_in; wd_ff <= wd_in;
            nl_ff <= nl_in; irc_ff <= irc_in; npad_ff <= npad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      od_ff <= od_in;
   end
endmodule
